// File: rtl/core/pfa_pkg.sv
// shared types and constants of the partition fit allocator
package pfa_pkg;

  localparam int AMOUNT_W    = 16;
  localparam int SLOT_W      = 4;
  localparam int IDX_OUT_W   = 4;
  localparam int POLICY_W    = 2;
  localparam int COUNT_W     = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  localparam logic [POLICY_W-1:0] POLICY_RESET = POL_FIRST;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd16;

  typedef struct packed {
    logic                action;
    logic [SLOT_W-1:0]   slot_index;
    logic [AMOUNT_W-1:0] amount;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } q_head_t;

endpackage

// File: rtl/core/pfa_if.sv
// request and result channel interfaces of the partition fit allocator
interface pfa_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [pfa_pkg::SLOT_W-1:0]   slot_index;
  logic [pfa_pkg::AMOUNT_W-1:0] amount;

  modport source (output valid, action, slot_index, amount, input ready);
  modport sink   (input valid, action, slot_index, amount, output ready);
endinterface

interface pfa_out_if;
  logic                          valid;
  logic                          ready;
  logic                          fit;
  logic [pfa_pkg::IDX_OUT_W-1:0] partition_index;
  logic [pfa_pkg::AMOUNT_W-1:0]  remaining_size;

  modport source (output valid, fit, partition_index, remaining_size, input ready);
  modport sink   (input valid, fit, partition_index, remaining_size, output ready);
endinterface

// File: rtl/core/pfa_front.sv
// input stage: takes beats and queues them for the allocation engine
module pfa_front (
  input  logic             clk,
  input  logic             rst_n,
  pfa_in_if.sink           in_chan,
  output pfa_pkg::q_head_t head,
  input  logic             pop
);
  import pfa_pkg::*;

  item_t             q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              push;
  logic              do_pop;
  item_t             in_item;

  assign in_chan.ready = (cnt_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push          = in_chan.valid & in_chan.ready;
  assign do_pop        = pop & (cnt_r != '0);

  assign in_item.action     = in_chan.action;
  assign in_item.slot_index = in_chan.slot_index;
  assign in_item.amount     = in_chan.amount;

  assign head.vld  = (cnt_r != '0);
  assign head.item = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/pfa_back.sv
// allocation engine: free size store, slot scan, write back and result register
module pfa_back #(
  parameter int NUM_PARTITIONS = 16,
  parameter int SIZE_BITS      = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pfa_pkg::q_head_t                head,
  output logic                            pop,
  input  logic [pfa_pkg::POLICY_W-1:0]    policy,
  input  logic [pfa_pkg::COUNT_W-1:0]     part_count,
  pfa_out_if.source                       out_chan
);
  import pfa_pkg::*;

  localparam int IDX_W = $clog2(NUM_PARTITIONS);
  localparam int CNT_W = IDX_W + 1;
  localparam int PC_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int SL_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int CMP_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t               state_r;
  logic [AMOUNT_W-1:0]  amt_r;
  logic [CNT_W-1:0]     k_r;
  logic                 cmp_go_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 found_r;
  logic [IDX_W-1:0]     pick_r;
  logic [SIZE_BITS-1:0] pick_size_r;
  logic                 out_valid_r;
  logic                 out_fit_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [AMOUNT_W-1:0]  out_rem_r;

  logic [SIZE_BITS-1:0] mem [NUM_PARTITIONS];
  logic [NUM_PARTITIONS-1:0] vld_r;
  logic [SIZE_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;

  logic [PC_W-1:0]      pc_ext;
  logic [CNT_W-1:0]     used;
  logic                 rd_en;
  logic                 slot_ok;
  logic                 load_wr;
  logic                 fin_wr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic                 out_free;
  logic [SIZE_BITS-1:0] s_cur;
  logic                 hit;
  logic                 take;
  logic [SIZE_BITS-1:0] diff;

  assign pc_ext  = PC_W'(part_count);
  assign used    = (pc_ext > PC_W'(NUM_PARTITIONS)) ? CNT_W'(NUM_PARTITIONS) : CNT_W'(pc_ext);
  assign rd_en   = (state_r == S_SCAN) && (k_r < used);
  assign slot_ok = SL_W'(head.item.slot_index) < SL_W'(NUM_PARTITIONS);
  assign pop     = (state_r == S_IDLE) && head.vld;
  assign out_free = !out_valid_r || out_chan.ready;

  assign load_wr = pop && (head.item.action == ACT_LOAD) && slot_ok;
  assign fin_wr  = (state_r == S_FINISH) && out_free && found_r;
  assign diff    = pick_size_r - SIZE_BITS'(amt_r);
  assign wr_en   = load_wr | fin_wr;
  assign wr_addr = load_wr ? IDX_W'(head.item.slot_index) : pick_r;
  assign wr_data = load_wr ? SIZE_BITS'(head.item.amount) : diff;

  assign s_cur = rd_vld_r ? rd_data_r : '0;
  assign hit   = cmp_go_r && (CMP_W'(s_cur) > CMP_W'(amt_r));
  assign take  = hit && (!found_r ||
                         ((policy == POL_BEST) && (s_cur < pick_size_r)) ||
                         ((policy == POL_WORST) && (s_cur > pick_size_r)));

  assign out_chan.valid           = out_valid_r;
  assign out_chan.fit             = out_fit_r;
  assign out_chan.partition_index = out_idx_r;
  assign out_chan.remaining_size  = out_rem_r;

  // free size store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[k_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[k_r[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_go_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (head.vld && (head.item.action == ACT_REQUEST)) begin
            amt_r    <= head.item.amount;
            k_r      <= '0;
            found_r  <= 1'b0;
            cmp_go_r <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_go_r  <= rd_en;
          cmp_idx_r <= k_r[IDX_W-1:0];
          if (rd_en) begin
            k_r <= k_r + 1'b1;
          end
          if (take) begin
            found_r     <= 1'b1;
            pick_r      <= cmp_idx_r;
            pick_size_r <= s_cur;
          end
          if (!rd_en && !cmp_go_r) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_fit_r   <= found_r | (amt_r == '0);
            out_idx_r   <= found_r ? IDX_OUT_W'(pick_r) : '0;
            out_rem_r   <= found_r ? AMOUNT_W'(diff) : '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/partition_fit_allocator.sv
// top level of the partition fit allocator: config registers, queue and engine
//
// in_chan carries one beat per item: a load (action 0) writes the free size of
// slot_index, a request (action 1) asks for amount. Each request gives exactly
// one beat on out_chan (fit, partition_index, remaining_size); loads give none.
// Items pass through a two-entry queue into the engine. A load writes the free
// size store as it is popped. A request is taken in S_IDLE; S_SCAN then reads
// the store once per slot below used = min(partition_count, NUM_PARTITIONS),
// drains the compare and leaves the scan; S_FINISH then writes back and loads
// the result register. The engine takes no new item until a request has left
// S_FINISH, so the per-slot scan sets the rate. Reset clears all free sizes to
// zero, policy to first fit and the partition count to 16. When out_chan
// stalls the finished result waits in its output register, the engine holds
// the next result, and the queue keeps taking beats until it is full.
// Configuration must be written by the user over the cfg_ port only while the
// block is idle, which the block does not enforce; pready is always high.
module partition_fit_allocator #(
  parameter int NUM_PARTITIONS = 16,
  parameter int SIZE_BITS      = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pfa_in_if.sink                           in_chan,
  pfa_out_if.source                        out_chan,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [pfa_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import pfa_pkg::*;

  logic [POLICY_W-1:0] policy_r;
  logic [COUNT_W-1:0]  count_r;
  logic                cfg_wr;
  logic                reg_sel;
  q_head_t             head;
  logic                pop;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (reg_sel == REG_COUNT) ? CFG_DATA_W'(count_r) : CFG_DATA_W'(policy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_RESET;
      count_r  <= COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_POLICY: policy_r <= cfg_pwdata[POLICY_W-1:0];
        REG_COUNT:  count_r  <= cfg_pwdata[COUNT_W-1:0];
        default:    policy_r <= policy_r;
      endcase
    end
  end

  pfa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .head    (head),
    .pop     (pop)
  );

  pfa_back #(
    .NUM_PARTITIONS (NUM_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .policy     (policy_r),
    .part_count (count_r),
    .out_chan   (out_chan)
  );

endmodule

// File: verif/tb_partition_fit_allocator.sv
// testbench of the partition fit allocator: directed table, then random phases per fit policy and partition count
`timescale 1ns / 100ps

module tb_partition_fit_allocator;
  import pfa_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int SETTLE_CYCLES   = 40;
  localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;

  typedef struct packed {
    logic                 fit;
    logic [IDX_OUT_W-1:0] idx;
    logic [AMOUNT_W-1:0]  rem;
  } grant_t;

  typedef struct packed {
    logic                 action;
    logic [SLOT_W-1:0]    slot;
    logic [AMOUNT_W-1:0]  amount;
    logic                 typed;
    logic                 fit;
    logic [IDX_OUT_W-1:0] idx;
    logic [AMOUNT_W-1:0]  rem;
  } directed_row_t;

  typedef struct packed {
    logic [POLICY_W-1:0] pol;
    logic [COUNT_W-1:0]  cnt;
    logic                wide;
  } phase_setting_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  pfa_in_if  in_bus();
  pfa_out_if out_bus();

  partition_fit_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_bus),
    .out_chan    (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  logic [AMOUNT_W-1:0] free_left [NUM_SLOTS];
  logic [POLICY_W-1:0] fit_policy;
  logic [COUNT_W-1:0]  slots_in_use;
  grant_t expected_grants[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit calm;

  directed_row_t directed_rows [0:20] = '{
    '{ACT_REQUEST, 4'd0,  16'h0001, 1'b1, 1'b0, 4'd0,  16'h0000},
    '{ACT_REQUEST, 4'd0,  16'h0000, 1'b1, 1'b1, 4'd0,  16'h0000},
    '{ACT_REQUEST, 4'd15, 16'hFFFF, 1'b1, 1'b0, 4'd0,  16'h0000},
    '{ACT_LOAD,    4'd0,  16'hFFFF, 1'b0, 1'b0, 4'd0,  16'h0000},
    '{ACT_REQUEST, 4'd0,  16'hFFFF, 1'b1, 1'b0, 4'd0,  16'h0000},
    '{ACT_REQUEST, 4'd0,  16'hFFFE, 1'b1, 1'b1, 4'd0,  16'h0001},
    '{ACT_LOAD,    4'd15, 16'hFFFF, 1'b0, 1'b0, 4'd0,  16'h0000},
    '{ACT_REQUEST, 4'd0,  16'h0000, 1'b1, 1'b1, 4'd0,  16'h0001},
    '{ACT_REQUEST, 4'd0,  16'h0001, 1'b1, 1'b1, 4'd15, 16'hFFFE},
    '{ACT_LOAD,    4'd7,  16'h8000, 1'b0, 1'b0, 4'd0,  16'h0000},
    '{ACT_LOAD,    4'd3,  16'h0005, 1'b0, 1'b0, 4'd0,  16'h0000},
    '{ACT_REQUEST, 4'd9,  16'h0004, 1'b0, 1'b0, 4'd0,  16'h0000},
    '{ACT_REQUEST, 4'd0,  16'h7FFF, 1'b0, 1'b0, 4'd0,  16'h0000},
    '{ACT_LOAD,    4'd0,  16'h0000, 1'b0, 1'b0, 4'd0,  16'h0000},
    '{ACT_LOAD,    4'd10, 16'hAAAA, 1'b0, 1'b0, 4'd0,  16'h0000},
    '{ACT_LOAD,    4'd5,  16'h5555, 1'b0, 1'b0, 4'd0,  16'h0000},
    '{ACT_REQUEST, 4'd0,  16'hFFFD, 1'b0, 1'b0, 4'd0,  16'h0000},
    '{ACT_REQUEST, 4'd6,  16'h0000, 1'b0, 1'b0, 4'd0,  16'h0000},
    '{ACT_REQUEST, 4'd0,  16'h5554, 1'b0, 1'b0, 4'd0,  16'h0000},
    '{ACT_LOAD,    4'd15, 16'h0000, 1'b0, 1'b0, 4'd0,  16'h0000},
    '{ACT_REQUEST, 4'd0,  16'hFFFF, 1'b1, 1'b0, 4'd0,  16'h0000}
  };

  phase_setting_t phase_plan [0:11] = '{
    '{POL_BEST,   5'd16, 1'b0},
    '{POL_WORST,  5'd16, 1'b0},
    '{POL_FIRST,  5'd16, 1'b1},
    '{POL_BEST,   5'd16, 1'b1},
    '{POL_WORST,  5'd16, 1'b1},
    '{POL_UNUSED, 5'd16, 1'b0},
    '{POL_BEST,   5'd1,  1'b0},
    '{POL_WORST,  5'd0,  1'b0},
    '{POL_FIRST,  5'd31, 1'b0},
    '{POL_BEST,   5'd17, 1'b1},
    '{POL_WORST,  5'd2,  1'b0},
    '{POL_FIRST,  5'd8,  1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
    error_count++;
  endtask

  // one allocation step; returns 1 when the item gives a result beat
  function automatic bit step_allocator(input item_t it, output grant_t g);
    int used;
    int pick;
    int k;
    bit found;
    g = '0;
    if (it.action == ACT_LOAD) begin
      free_left[it.slot_index] = it.amount;
      return 1'b0;
    end
    used = (slots_in_use > NUM_SLOTS) ? NUM_SLOTS : int'(slots_in_use);
    found = 1'b0;
    pick = 0;
    for (k = 0; k < used; k++) begin
      if (free_left[k] > it.amount) begin
        if (!found) begin
          found = 1'b1;
          pick = k;
          if (fit_policy != POL_BEST && fit_policy != POL_WORST) break;
        end else if (fit_policy == POL_BEST && free_left[k] < free_left[pick]) begin
          pick = k;
        end else if (fit_policy == POL_WORST && free_left[k] > free_left[pick]) begin
          pick = k;
        end
      end
    end
    if (found) begin
      free_left[pick] = free_left[pick] - it.amount;
      g.fit = 1'b1;
      g.idx = pick[IDX_OUT_W-1:0];
      g.rem = free_left[pick];
    end else begin
      g.fit = (it.amount == '0);
    end
    return 1'b1;
  endfunction

  function automatic int gap_cycles();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic item_t random_item(input bit wide);
    item_t it;
    int sel;
    int k;
    it.slot_index = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    sel = $urandom_range(0, 9);
    if ($urandom_range(0, 99) < 35) begin
      it.action = ACT_LOAD;
      if (sel == 0) it.amount = '0;
      else if (sel == 1) it.amount = '1;
      else if (wide) it.amount = AMOUNT_W'($urandom);
      else it.amount = AMOUNT_W'($urandom_range(0, 30));
    end else begin
      it.action = ACT_REQUEST;
      k = $urandom_range(0, NUM_SLOTS - 1);
      if (sel == 0) it.amount = '0;
      else if (sel == 1) it.amount = '1;
      else if (sel == 2) it.amount = free_left[k];
      else if (sel == 3) it.amount = (free_left[k] == '0) ? '0 : free_left[k] - 1'b1;
      else if (wide) it.amount = AMOUNT_W'($urandom);
      else it.amount = AMOUNT_W'($urandom_range(0, 24));
    end
    return it;
  endfunction

  task automatic send_item(input item_t it, input bit typed, input grant_t typed_g);
    int gap;
    bit has_result;
    grant_t g;
    gap = gap_cycles();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.action     <= it.action;
    in_bus.slot_index <= it.slot_index;
    in_bus.amount     <= it.amount;
    do @(posedge clk); while (!in_bus.ready);
    has_result = step_allocator(it, g);
    if (has_result) expected_grants.push_back(typed ? typed_g : g);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (reg_sel == REG_POLICY) fit_policy = value[POLICY_W-1:0];
    else slots_in_use = value[COUNT_W-1:0];
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_bus.ready <= 1'b1;
    end else if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_bus.ready <= 1'b1;
      if ($urandom_range(0, 99) < 15) hold_left <= $urandom_range(1, 3);
      else if ($urandom_range(0, 99) < 3) hold_left <= $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin : check_beats
    grant_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready) begin
      if (expected_grants.size() == 0) begin
        report_mismatch("result beat with nothing pending", 32'(out_bus.remaining_size), 0);
      end else begin
        want = expected_grants.pop_front();
        if (out_bus.fit !== want.fit)
          report_mismatch("fit", 32'(out_bus.fit), 32'(want.fit));
        if (out_bus.partition_index !== want.idx)
          report_mismatch("partition_index", 32'(out_bus.partition_index), 32'(want.idx));
        if (out_bus.remaining_size !== want.rem)
          report_mismatch("remaining_size", 32'(out_bus.remaining_size), 32'(want.rem));
      end
    end
  end

  initial begin
    item_t it;
    grant_t typed_g;
    int ph;
    int n;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_LOAD;
    in_bus.slot_index = '0;
    in_bus.amount = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    calm = 1'b0;
    fit_policy = POLICY_RESET;
    slots_in_use = COUNT_RESET;
    for (n = 0; n < NUM_SLOTS; n++) free_left[n] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      it.action     = directed_rows[i].action;
      it.slot_index = directed_rows[i].slot;
      it.amount     = directed_rows[i].amount;
      typed_g       = '{directed_rows[i].fit, directed_rows[i].idx, directed_rows[i].rem};
      send_item(it, directed_rows[i].typed, typed_g);
    end

    for (ph = 0; ph < 12; ph++) begin
      wait_idle();
      cfg_write(REG_POLICY, CFG_DATA_W'(phase_plan[ph].pol));
      cfg_write(REG_COUNT, CFG_DATA_W'(phase_plan[ph].cnt));
      @(posedge clk);
      calm = (ph % 4 == 2);
      for (n = 0; n < ITEMS_PER_PHASE; n++)
        send_item(random_item(phase_plan[ph].wide), 1'b0, '0);
    end

    wait_idle();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pfa_pkg.sv
rtl/core/pfa_if.sv
rtl/core/pfa_front.sv
rtl/core/pfa_back.sv
rtl/core/partition_fit_allocator.sv
verif/tb_partition_fit_allocator.sv
